/* src/drld_pkg.sv */
`default_nettype none
package drld_pkg;

  localparam int MAX_FIELD_BYTES = 8;

  localparam int CSIZE_W = 22;
  localparam int VSIZE_W = 48;
  localparam int WORD_W  = 64;
  localparam int QUOT_W  = VSIZE_W + 1;
  localparam int PROD_W  = WORD_W + CSIZE_W;

  localparam int DIV_STEPS = QUOT_W;
  localparam int MUL_STEPS = CSIZE_W;

  localparam int DCNT_W = $clog2(DIV_STEPS);
  localparam int MCNT_W = $clog2(MUL_STEPS);

  // register indexes of the configuration port
  localparam logic [1:0] REG_CLUSTER_SIZE = 2'd0;
  localparam logic [1:0] REG_VALUE_SIZE   = 2'd1;

  localparam logic [CSIZE_W-1:0] CLUSTER_SIZE_RESET = CSIZE_W'(4096);

  // parse phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_COUNT  = 2'd1;
  localparam logic [1:0] PH_DELTA  = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_RUN       = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_ZERO_CNT  = 3'd4;
  localparam logic [2:0] ST_NEG_LCN   = 3'd5;
  localparam logic [2:0] ST_OVERFLOW  = 3'd6;
  localparam logic [2:0] ST_SHORT     = 3'd7;

  // multiplier operand select
  localparam logic [1:0] MS_COUNT = 2'd0;
  localparam logic [1:0] MS_LAST  = 2'd1;
  localparam logic [1:0] MS_START = 2'd2;

  typedef struct packed {
    logic       take_byte;
    logic       div_step;
    logic       sel;
    logic       chk;
    logic       mul_start;
    logic [1:0] mul_sel;
    logic       mul_step;
    logic       disp;
    logic       postl;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic run_go;
    logic div_done;
    logic short_run;
    logic go_last;
    logic prod_ovf;
    logic mul_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* src/drld_ctrl.sv */
`default_nettype none
module drld_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire drld_pkg::stat_t stat,
  output drld_pkg::cmd_t     cmd
);
  import drld_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_SEL   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_MULB  = 4'd4;
  localparam logic [3:0] S_DISP  = 4'd5;
  localparam logic [3:0] S_MULL  = 4'd6;
  localparam logic [3:0] S_POSTL = 4'd7;
  localparam logic [3:0] S_MULS  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = !((state == S_IDLE) && stat.out_free);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.take_byte = 1'b1;
          if (stat.run_go) state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_SEL;
      end
      S_SEL: begin
        cmd.sel = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (stat.short_run) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel = MS_COUNT;
          state_next = S_MULB;
        end else begin
          state_next = S_DISP;
        end
      end
      S_MULB: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done) state_next = S_DISP;
      end
      S_DISP: begin
        cmd.disp = 1'b1;
        if (stat.go_last) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel = MS_LAST;
          state_next = S_MULL;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MULL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done) state_next = S_POSTL;
      end
      S_POSTL: begin
        cmd.postl = 1'b1;
        if (!stat.prod_ovf) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel = MS_START;
          state_next = S_MULS;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MULS: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* src/drld_datapath.sv */
`default_nettype none
module drld_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire drld_pkg::cmd_t        cmd,
  output drld_pkg::stat_t            stat,
  input  wire logic [7:0]            mapping_byte,
  input  wire logic                  region_end,
  input  wire logic                  cfg_valid,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [47:0]           cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [62:0]                run_lcn,
  output logic [63:0]                run_byte_offset,
  output logic [63:0]                run_cluster_count,
  output logic [47:0]                run_bytes,
  output logic                       sparse_run,
  output logic [2:0]                 status,
  output logic                       last_result
);
  import drld_pkg::*;

  // configuration
  logic [CSIZE_W-1:0] bpc;
  logic [VSIZE_W-1:0] vsize;

  // parse state
  logic [1:0]         phase, phase_next;
  logic [3:0]         lsz, lsz_next;
  logic [3:0]         osz, osz_next;
  logic [3:0]         idx, idx_next;
  logic [WORD_W-1:0]  cnt_acc, cnt_acc_next;
  logic [WORD_W-1:0]  dlt_acc, dlt_acc_next;
  logic [WORD_W-1:0]  cur, cur_next;
  logic [VSIZE_W-1:0] produced, produced_next;
  logic               out_valid_next;

  // run-end working registers
  logic               end_q, end_q_next;
  logic [VSIZE_W-1:0] rem, rem_next;
  logic [QUOT_W-1:0]  dq, dq_next;
  logic [CSIZE_W-1:0] dr, dr_next;
  logic [DCNT_W-1:0]  dcnt, dcnt_next;
  logic               short_q, short_q_next;
  logic [WORD_W-1:0]  used_m1, used_m1_next;
  logic [WORD_W-1:0]  start, start_next;
  logic [WORD_W-1:0]  last, last_next;
  logic               e5, e5_next;
  logic               e6, e6_next;
  logic               ovf, ovf_next;
  logic [VSIZE_W-1:0] bytes_q, bytes_q_next;
  logic [PROD_W-1:0]  macc, macc_next;
  logic [WORD_W-1:0]  ma, ma_next;
  logic [MCNT_W-1:0]  mcnt, mcnt_next;
  logic               run_go;

  // result register
  logic [62:0]        o_lcn_next;
  logic [63:0]        o_off_next;
  logic [63:0]        o_cnt_next;
  logic [47:0]        o_bytes_next;
  logic               o_sparse_next;
  logic [2:0]         o_status_next;
  logic               o_last_next;

  // sign-extended delta
  logic [WORD_W-1:0]  dext;
  logic [3:0]         osz_dec;
  logic               sgn;

  always_comb begin
    osz_dec = osz - 4'd1;
    sgn = dlt_acc[{osz_dec[2:0], 3'b111}];
    for (int k = 0; k < 8; k++) begin
      dext[8*k +: 8] = (4'(k) < osz) ? dlt_acc[8*k +: 8] : {8{sgn}};
    end
  end

  assign stat.run_go    = run_go;
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.div_done  = (dcnt == '0);
  assign stat.mul_done  = (mcnt == '0);
  assign stat.short_run = short_q;
  assign stat.go_last   = (osz != 4'd0) && !e5 && !e6;
  assign stat.prod_ovf  = |macc[PROD_W-1:WORD_W];

  always_comb begin
    logic [3:0]         lsz_b;
    logic [3:0]         osz_b;
    logic [3:0]         idx_inc;
    logic [WORD_W-1:0]  byte_sh;
    logic [WORD_W-1:0]  cnt_val;
    logic               fin_en;
    logic [2:0]         fin_code;
    logic               close_en;
    logic               close_end;
    logic               rstart;
    logic [WORD_W-1:0]  used;
    logic [22:0]        rsh;
    logic               ge;
    logic [VSIZE_W-1:0] pn;
    logic [2:0]         rst_code;

    lsz_b = mapping_byte[3:0];
    osz_b = mapping_byte[7:4];
    idx_inc = idx + 4'd1;
    byte_sh = {56'd0, mapping_byte} << {idx[2:0], 3'b000};
    cnt_val = cnt_acc;
    fin_en = 1'b0;
    fin_code = ST_RUN;
    close_en = 1'b0;
    close_end = 1'b0;
    rstart = 1'b0;
    used = '0;
    rsh = '0;
    ge = 1'b0;
    pn = '0;
    rst_code = ST_RUN;

    phase_next = phase;
    lsz_next = lsz;
    osz_next = osz;
    idx_next = idx;
    cnt_acc_next = cnt_acc;
    dlt_acc_next = dlt_acc;
    cur_next = cur;
    produced_next = produced;
    out_valid_next = out_valid && out_stall;
    end_q_next = end_q;
    rem_next = rem;
    dq_next = dq;
    dr_next = dr;
    dcnt_next = dcnt;
    short_q_next = short_q;
    used_m1_next = used_m1;
    start_next = start;
    last_next = last;
    e5_next = e5;
    e6_next = e6;
    ovf_next = ovf;
    bytes_q_next = bytes_q;
    macc_next = macc;
    ma_next = ma;
    mcnt_next = mcnt;
    o_lcn_next = run_lcn;
    o_off_next = run_byte_offset;
    o_cnt_next = run_cluster_count;
    o_bytes_next = run_bytes;
    o_sparse_next = sparse_run;
    o_status_next = status;
    o_last_next = last_result;
    run_go = 1'b0;

    if (cmd.take_byte) begin
      case (phase)
        PH_HEADER: begin
          if (bpc == '0) begin
            fin_en = 1'b1; fin_code = ST_BAD_HDR;
          end else if (produced >= vsize) begin
            fin_en = 1'b1; fin_code = ST_COMPLETE;
          end else if (mapping_byte == 8'd0) begin
            fin_en = 1'b1; fin_code = ST_SHORT;
          end else if (lsz_b == 4'd0 || lsz_b > 4'(MAX_FIELD_BYTES)
                       || osz_b > 4'(MAX_FIELD_BYTES)) begin
            fin_en = 1'b1; fin_code = ST_BAD_HDR;
          end else if (region_end) begin
            fin_en = 1'b1; fin_code = ST_TRUNC;
          end else begin
            lsz_next = lsz_b;
            osz_next = osz_b;
            idx_next = 4'd0;
            cnt_acc_next = '0;
            dlt_acc_next = '0;
            phase_next = PH_COUNT;
          end
        end
        PH_COUNT: begin
          cnt_val = cnt_acc | byte_sh;
          cnt_acc_next = cnt_val;
          idx_next = idx_inc;
          if (idx_inc < lsz) begin
            if (region_end) begin
              fin_en = 1'b1; fin_code = ST_TRUNC;
            end
          end else if (osz != 4'd0) begin
            if (region_end) begin
              fin_en = 1'b1; fin_code = ST_TRUNC;
            end else begin
              idx_next = 4'd0;
              phase_next = PH_DELTA;
            end
          end else begin
            rstart = 1'b1;
          end
        end
        PH_DELTA: begin
          dlt_acc_next = dlt_acc | byte_sh;
          idx_next = idx_inc;
          if (idx_inc < osz) begin
            if (region_end) begin
              fin_en = 1'b1; fin_code = ST_TRUNC;
            end
          end else begin
            rstart = 1'b1;
          end
        end
        default: begin
          if (region_end) begin
            close_en = 1'b1;
            close_end = 1'b1;
          end
        end
      endcase

      if (rstart) begin
        if (cnt_val == '0) begin
          fin_en = 1'b1; fin_code = ST_ZERO_CNT;
        end else if (bpc == '0) begin
          fin_en = 1'b1; fin_code = ST_BAD_HDR;
        end else begin
          run_go = 1'b1;
          end_q_next = region_end;
          rem_next = vsize - produced;
          dq_next = {1'b0, vsize - produced} + {27'd0, bpc} - 49'd1;
          dr_next = '0;
          dcnt_next = DCNT_W'(DIV_STEPS - 1);
        end
      end
      if (fin_en) close_end = region_end;
    end

    // restoring divide, one quotient bit a cycle
    if (cmd.div_step) begin
      rsh = {dr, dq[QUOT_W-1]};
      ge = rsh >= {1'b0, bpc};
      dr_next = ge ? 22'(rsh - {1'b0, bpc}) : rsh[21:0];
      dq_next = {dq[QUOT_W-2:0], ge};
      dcnt_next = dcnt - 1'b1;
    end

    if (cmd.sel) begin
      short_q_next = cnt_acc < {15'd0, dq};
      used = (cnt_acc < {15'd0, dq}) ? cnt_acc : {15'd0, dq};
      used_m1_next = used - 64'd1;
      start_next = (osz == 4'd0) ? cur : cur + dext;
      bytes_q_next = rem;
      ovf_next = 1'b0;
    end

    if (cmd.chk) begin
      e5_next = (osz != 4'd0) && start[WORD_W-1];
      e6_next = (osz != 4'd0) && !start[WORD_W-1] && (used_m1 > ~start);
      last_next = start + used_m1;
    end

    if (cmd.disp && short_q) bytes_q_next = macc[VSIZE_W-1:0];

    if (cmd.postl) ovf_next = |macc[PROD_W-1:WORD_W];

    // shift-add multiply by the cluster size, msb first
    if (cmd.mul_start) begin
      macc_next = '0;
      mcnt_next = MCNT_W'(MUL_STEPS - 1);
      case (cmd.mul_sel)
        MS_COUNT: ma_next = cnt_acc;
        MS_LAST:  ma_next = last;
        default:  ma_next = start;
      endcase
    end
    if (cmd.mul_step) begin
      macc_next = {macc[PROD_W-2:0], 1'b0}
                  + (bpc[mcnt] ? {{CSIZE_W{1'b0}}, ma} : '0);
      mcnt_next = mcnt - 1'b1;
    end

    if (cmd.fin) begin
      if (e5) begin
        fin_en = 1'b1; fin_code = ST_NEG_LCN; close_end = end_q;
      end else if (e6 || ovf) begin
        fin_en = 1'b1; fin_code = ST_OVERFLOW; close_end = end_q;
      end else begin
        pn = produced + bytes_q;
        if (pn >= vsize) rst_code = ST_COMPLETE;
        else if (end_q) rst_code = ST_SHORT;
        else rst_code = ST_RUN;
        produced_next = pn;
        if (osz != 4'd0) cur_next = start;
        o_lcn_next = (osz == 4'd0) ? '0 : start[62:0];
        o_off_next = (osz == 4'd0) ? '0 : macc[WORD_W-1:0];
        o_cnt_next = cnt_acc;
        o_bytes_next = bytes_q;
        o_sparse_next = (osz == 4'd0);
        o_status_next = rst_code;
        o_last_next = (rst_code != ST_RUN);
        out_valid_next = 1'b1;
        if (rst_code != ST_RUN) begin
          close_en = 1'b1;
          close_end = end_q;
        end else begin
          phase_next = PH_HEADER;
          idx_next = 4'd0;
        end
      end
    end

    if (fin_en) begin
      o_lcn_next = '0;
      o_off_next = '0;
      o_cnt_next = '0;
      o_bytes_next = '0;
      o_sparse_next = 1'b0;
      o_status_next = fin_code;
      o_last_next = 1'b1;
      out_valid_next = 1'b1;
      close_en = 1'b1;
    end

    if (close_en) begin
      if (close_end) begin
        phase_next = PH_HEADER;
        lsz_next = 4'd0;
        osz_next = 4'd0;
        idx_next = 4'd0;
        cnt_acc_next = '0;
        dlt_acc_next = '0;
        cur_next = '0;
        produced_next = '0;
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bpc <= CLUSTER_SIZE_RESET;
      vsize <= '0;
      phase <= PH_HEADER;
      lsz <= 4'd0;
      osz <= 4'd0;
      idx <= 4'd0;
      cnt_acc <= '0;
      dlt_acc <= '0;
      cur <= '0;
      produced <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CLUSTER_SIZE: bpc <= cfg_data[CSIZE_W-1:0];
          REG_VALUE_SIZE:   vsize <= cfg_data[VSIZE_W-1:0];
          default: ;
        endcase
      end
      phase <= phase_next;
      lsz <= lsz_next;
      osz <= osz_next;
      idx <= idx_next;
      cnt_acc <= cnt_acc_next;
      dlt_acc <= dlt_acc_next;
      cur <= cur_next;
      produced <= produced_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    end_q <= end_q_next;
    rem <= rem_next;
    dq <= dq_next;
    dr <= dr_next;
    dcnt <= dcnt_next;
    short_q <= short_q_next;
    used_m1 <= used_m1_next;
    start <= start_next;
    last <= last_next;
    e5 <= e5_next;
    e6 <= e6_next;
    ovf <= ovf_next;
    bytes_q <= bytes_q_next;
    macc <= macc_next;
    ma <= ma_next;
    mcnt <= mcnt_next;
    run_lcn <= o_lcn_next;
    run_byte_offset <= o_off_next;
    run_cluster_count <= o_cnt_next;
    run_bytes <= o_bytes_next;
    sparse_run <= o_sparse_next;
    status <= o_status_next;
    last_result <= o_last_next;
  end

endmodule
`default_nettype wire

/* src/data_run_list_decoder.sv */
`default_nettype none
// channel   direction  handshake                    payload
// in        input      in_valid / in_stall          mapping_byte, region_end
// out       output     out_valid / out_stall        run_lcn .. last_result
// cfg       input      cfg_valid / cfg_ready        cfg_index, cfg_data
//
// header, count and delta bytes are taken while the decoder is idle. the byte that ends
// a run starts a restoring divide and up to three shift-add multiplies by the cluster
// size before the extent appears.
// rst is synchronous; the cluster size returns to 4096, the value size to 0.
// a new byte is taken while the result register drains in the same cycle.
module data_run_list_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  mapping_byte,
  input  wire logic        region_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [62:0]      run_lcn,
  output logic [63:0]      run_byte_offset,
  output logic [63:0]      run_cluster_count,
  output logic [47:0]      run_bytes,
  output logic             sparse_run,
  output logic [2:0]       status,
  output logic             last_result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  import drld_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  drld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  drld_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .mapping_byte      (mapping_byte),
    .region_end        (region_end),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .run_lcn           (run_lcn),
    .run_byte_offset   (run_byte_offset),
    .run_cluster_count (run_cluster_count),
    .run_bytes         (run_bytes),
    .sparse_run        (sparse_run),
    .status            (status),
    .last_result       (last_result)
  );

endmodule
`default_nettype wire

/* tb/sv/data_run_list_decoder_tb.sv */
`timescale 1ns / 100ps
module data_run_list_decoder_tb;
  import drld_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [62:0] lcn;
    logic [63:0] offset;
    logic [63:0] count;
    logic [47:0] nbytes;
    logic        sparse;
    logic [2:0]  st;
    logic        last;
  } extent_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_BYTE_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [7:0]  b;
    logic        e;
    logic [2:0]  st;
    logic [1:0]  idx;
    logic [47:0] data;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  mapping_byte = '0;
  logic        region_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [62:0] run_lcn;
  logic [63:0] run_byte_offset;
  logic [63:0] run_cluster_count;
  logic [47:0] run_bytes;
  logic        sparse_run;
  logic [2:0]  status;
  logic        last_result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  data_run_list_decoder DUT (.*);

  always #5 clk = ~clk;

  // decoder image
  logic [21:0] m_csize;
  logic [47:0] m_vsize;
  logic [1:0]  m_phase;
  logic [3:0]  m_lsz, m_osz, m_idx;
  logic [63:0] m_cnt, m_delta, m_cluster;
  logic [47:0] m_produced;

  extent_t extent_q[$];
  row_t    rows[$];
  int      errors = 0;
  int      n_items = 0, n_results = 0, n_errors_seen = 0, n_sparse = 0, n_cfg = 0;
  bit      quiet = 1'b0;
  int      ostall_left = 0;
  int      idle_cycles = 0;

  task automatic clear_attr();
    m_phase = PH_HEADER;
    m_lsz = '0; m_osz = '0; m_idx = '0;
    m_cnt = '0; m_delta = '0; m_cluster = '0; m_produced = '0;
  endtask

  task automatic close_out(input logic [2:0] st, input logic e, output extent_t r);
    r = '{default: '0};
    r.st = st;
    r.last = 1'b1;
    if (e) clear_attr();
    else m_phase = PH_DONE;
  endtask

  task automatic end_of_run(input logic e, output extent_t r);
    logic [63:0] bpc, rem, needed, used, nb, start, lastc, d;
    logic [2:0]  st;
    bit          sp;
    bpc = 64'(m_csize);
    sp = (m_osz == 0);
    if (m_cnt == 0) begin
      close_out(ST_ZERO_CNT, e, r);
      return;
    end
    if (bpc == 0) begin
      close_out(ST_BAD_HDR, e, r);
      return;
    end
    rem = 64'(m_vsize) - 64'(m_produced);
    needed = (rem + bpc - 64'd1) / bpc;
    if (m_cnt >= needed) begin
      used = needed; nb = rem;
    end else begin
      used = m_cnt; nb = m_cnt * bpc;
    end
    start = m_cluster;
    if (!sp) begin
      d = m_delta;
      if (m_osz < 8 && d[8*m_osz-1]) d = d | ({64{1'b1}} << (8*m_osz));
      start = m_cluster + d;
      if (start[63]) begin
        close_out(ST_NEG_LCN, e, r);
        return;
      end
      if (used - 64'd1 > ~64'd0 - start) begin
        close_out(ST_OVERFLOW, e, r);
        return;
      end
      lastc = start + (used - 64'd1);
      if (lastc > ~64'd0 / bpc) begin
        close_out(ST_OVERFLOW, e, r);
        return;
      end
      m_cluster = start;
    end
    m_produced = 48'(64'(m_produced) + nb);
    if (m_produced >= m_vsize) st = ST_COMPLETE;
    else if (e) st = ST_SHORT;
    else st = ST_RUN;
    r.lcn = sp ? '0 : start[62:0];
    r.offset = sp ? '0 : start * bpc;
    r.count = m_cnt;
    r.nbytes = nb[47:0];
    r.sparse = sp;
    r.st = st;
    r.last = (st != ST_RUN);
    if (st != ST_RUN) begin
      if (e) clear_attr();
      else m_phase = PH_DONE;
    end else begin
      m_phase = PH_HEADER;
      m_idx = '0;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic e, output bit got,
                             output extent_t r);
    logic [3:0] lsz, osz;
    got = 1'b1;
    r = '{default: '0};
    case (m_phase)
      PH_HEADER: begin
        lsz = b[3:0];
        osz = b[7:4];
        if (m_csize == 0) close_out(ST_BAD_HDR, e, r);
        else if (m_produced >= m_vsize) close_out(ST_COMPLETE, e, r);
        else if (b == 0) close_out(ST_SHORT, e, r);
        else if (lsz == 0 || lsz > MAX_FIELD_BYTES || osz > MAX_FIELD_BYTES)
          close_out(ST_BAD_HDR, e, r);
        else if (e) close_out(ST_TRUNC, e, r);
        else begin
          m_lsz = lsz; m_osz = osz; m_idx = '0;
          m_cnt = '0; m_delta = '0;
          m_phase = PH_COUNT;
          got = 1'b0;
        end
      end
      PH_COUNT: begin
        m_cnt = m_cnt | (64'(b) << (8 * m_idx[2:0]));
        m_idx = m_idx + 4'd1;
        if (m_idx < m_lsz) begin
          if (e) close_out(ST_TRUNC, e, r);
          else got = 1'b0;
        end else if (m_osz != 0) begin
          if (e) close_out(ST_TRUNC, e, r);
          else begin
            m_idx = '0;
            m_phase = PH_DELTA;
            got = 1'b0;
          end
        end else end_of_run(e, r);
      end
      PH_DELTA: begin
        m_delta = m_delta | (64'(b) << (8 * m_idx[2:0]));
        m_idx = m_idx + 4'd1;
        if (m_idx < m_osz) begin
          if (e) close_out(ST_TRUNC, e, r);
          else got = 1'b0;
        end else end_of_run(e, r);
      end
      default: begin
        if (e) clear_attr();
        got = 1'b0;
      end
    endcase
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  // inputs change on the falling edge
  task automatic send_byte(input logic [7:0] b, input logic e, input logic [2:0] st = '0,
                           input bit typed = 1'b0);
    int      gap;
    bit      got;
    extent_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    mapping_byte = b;
    region_end = e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    decode_byte(b, e, got, r);
    if (typed) begin
      r = '{default: '0};
      r.st = st;
      r.last = 1'b1;
      got = 1'b1;
    end
    if (got) extent_q.push_back(r);
  endtask

  // wait for the block to go quiet, then let a run end settle
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (extent_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
    wait_quiet();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_cfg++;
    if (idx == REG_CLUSTER_SIZE) m_csize = data[21:0];
    else if (idx == REG_VALUE_SIZE) m_vsize = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic row_b(input logic [7:0] b, input logic e);
    rows.push_back('{ROW_BYTE, b, e, '0, '0, '0});
  endtask

  task automatic row_t_(input logic [7:0] b, input logic e, input logic [2:0] st);
    rows.push_back('{ROW_BYTE_TYPED, b, e, st, '0, '0});
  endtask

  task automatic row_c(input logic [1:0] idx, input logic [47:0] data);
    rows.push_back('{ROW_CFG, '0, '0, '0, idx, data});
  endtask

  // one attribute: mostly well-formed runs, some noise, region end on the last byte
  task automatic send_attribute();
    int nruns, lsz, osz;
    logic [7:0] bytes_q[$];
    nruns = $urandom_range(1, 6);
    for (int r = 0; r < nruns; r++) begin
      if ($urandom_range(0, 9) == 0) begin
        bytes_q.push_back(8'($urandom));
        continue;
      end
      lsz = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2);
      case ($urandom_range(0, 7))
        0, 1:    osz = 0;
        2:       osz = $urandom_range(3, 8);
        default: osz = $urandom_range(1, 2);
      endcase
      bytes_q.push_back({4'(osz), 4'(lsz)});
      for (int i = 0; i < lsz; i++)
        bytes_q.push_back((i == lsz - 1 && $urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15))
                                                                         : 8'($urandom));
      for (int i = 0; i < osz; i++) bytes_q.push_back(8'($urandom));
    end
    if ($urandom_range(0, 1)) bytes_q.push_back(8'h00);
    bytes_q.push_back(8'($urandom));
    // occasionally cut the attribute short
    if ($urandom_range(0, 9) == 0 && bytes_q.size() > 2)
      bytes_q = bytes_q[0:$urandom_range(1, bytes_q.size() - 2)];
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  task automatic random_config();
    logic [47:0] v;
    case ($urandom_range(0, 4))
      0: v = 48'd1;
      1: v = 48'd512;
      2: v = 48'd2097152;
      3: v = 48'd4096;
      default: v = 48'($urandom_range(1, 2097152));
    endcase
    write_reg(REG_CLUSTER_SIZE, v);
    case ($urandom_range(0, 5))
      0: v = 48'd0;
      1: v = {48{1'b1}};
      2: v = 48'({$urandom, $urandom});
      default: v = 48'($urandom_range(1, 1 << 22));
    endcase
    write_reg(REG_VALUE_SIZE, v);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? 2'd2 : 2'd3, 48'({$urandom, $urandom}));
  endtask

  // result side: stall bursts applied on the falling edge
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
    end else if (ostall_left > 0) begin
      ostall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      ostall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    extent_t w;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (extent_q.size() == 0) begin
        report("result with nothing pending", {61'd0, status}, '0);
      end else begin
        w = extent_q.pop_front();
        if (status > ST_COMPLETE) n_errors_seen++;
        if (sparse_run) n_sparse++;
        if (run_lcn !== w.lcn) report("run_lcn", 64'(run_lcn), 64'(w.lcn));
        if (run_byte_offset !== w.offset) report("run_byte_offset", run_byte_offset, w.offset);
        if (run_cluster_count !== w.count) report("run_cluster_count", run_cluster_count, w.count);
        if (run_bytes !== w.nbytes) report("run_bytes", 64'(run_bytes), 64'(w.nbytes));
        if (sparse_run !== w.sparse) report("sparse_run", 64'(sparse_run), 64'(w.sparse));
        if (status !== w.st) report("status", 64'(status), 64'(w.st));
        if (last_result !== w.last) report("last_result", 64'(last_result), 64'(w.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", extent_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    m_csize = CLUSTER_SIZE_RESET;
    m_vsize = '0;
    clear_attr();

    // value size zero after reset: filled at once
    row_t_(8'h11, 1'b0, ST_COMPLETE);
    row_b(8'h55, 1'b1);
    row_c(REG_VALUE_SIZE, 48'd10000);
    row_t_(8'h00, 1'b0, ST_SHORT);
    row_b(8'hAA, 1'b1);
    row_t_(8'h10, 1'b1, ST_BAD_HDR);
    row_t_(8'h19, 1'b1, ST_BAD_HDR);
    row_t_(8'h91, 1'b1, ST_BAD_HDR);
    row_t_(8'h11, 1'b1, ST_TRUNC);
    row_b(8'h11, 1'b0);
    row_t_(8'h05, 1'b1, ST_TRUNC);
    row_b(8'h01, 1'b0);
    row_t_(8'h00, 1'b1, ST_ZERO_CNT);
    row_b(8'h11, 1'b0);
    row_b(8'h02, 1'b0);
    row_t_(8'h80, 1'b1, ST_NEG_LCN);
    // normal run then a sparse run that fills the value
    row_b(8'h21, 1'b0); row_b(8'h01, 1'b0); row_b(8'h00, 1'b0); row_b(8'h10, 1'b0);
    row_b(8'h01, 1'b0); row_b(8'h02, 1'b0);
    row_b(8'h00, 1'b1);
    // largest positive delta, end of volume overflow
    row_b(8'h81, 1'b0); row_b(8'h02, 1'b0);
    for (int i = 0; i < 7; i++) row_b(8'hFF, 1'b0);
    row_t_(8'h7F, 1'b1, ST_OVERFLOW);
    row_c(REG_CLUSTER_SIZE, 48'd0);
    row_t_(8'h11, 1'b1, ST_BAD_HDR);
    row_c(REG_CLUSTER_SIZE, 48'd1);
    row_c(REG_VALUE_SIZE, {48{1'b1}});
    row_c(2'd2, {48{1'b1}});
    row_b(8'h88, 1'b0);
    for (int i = 0; i < 8; i++) row_b(8'hFF, 1'b0);
    for (int i = 0; i < 7; i++) row_b(8'h01, 1'b0);
    row_b(8'h00, 1'b1);
    row_c(REG_CLUSTER_SIZE, 48'd2097152);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG:        write_reg(rows[i].idx, rows[i].data);
        ROW_BYTE_TYPED: send_byte(rows[i].b, rows[i].e, rows[i].st, 1'b1);
        default:        send_byte(rows[i].b, rows[i].e);
      endcase
    end

    while (n_items < 830) begin
      random_config();
      for (int a = 0; a < 8 && n_items < 830; a++) begin
        if (n_items > 720) quiet = 1'b1;
        send_attribute();
        if (a == 4 && $urandom_range(0, 1)) wait_quiet();
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (extent_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d bytes sent, %0d extents checked (%0d sparse, %0d error status)",
             n_items, n_results, n_sparse, n_errors_seen);
    $display("%0d register writes across cluster and value sizes", n_cfg);
    if (errors == 0 && extent_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d extents left pending", errors, extent_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/drld_pkg.sv
src/drld_ctrl.sv
src/drld_datapath.sv
src/data_run_list_decoder.sv
tb/sv/data_run_list_decoder_tb.sv
